// ===== hw/rtl/sks_pkg.sv =====
`timescale 1ns / 1ps

package sks_pkg;

	localparam int MAX_SEED_LEN = 32;
	localparam int KEY_CHARS = 12;
	localparam int KEY_BYTES = KEY_CHARS / 2;

	localparam int ADDR_W = (MAX_SEED_LEN > 1) ? $clog2(MAX_SEED_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_SEED_LEN + 1);
	localparam int SUM_W = $clog2(9 * MAX_SEED_LEN + 1);
	localparam int BIT_W = $clog2(SUM_W);
	localparam int J_W = $clog2(KEY_CHARS);

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_Z_LO = 8'h7a;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] NIB_TEN = 8'h0a;
	localparam logic [7:0] MIRROR_K = 8'd219;

	typedef struct packed {
		logic [7:0] seed_char;
		logic       seed_last;
	} seed_req_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       key_last;
		logic       seed_overflow;
	} key_req_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [7:0] mirror(input logic [7:0] c);
		if (is_digit(c)) begin
			return CH_9 + CH_0 - c;
		end
		return MIRROR_K - c;
	endfunction

	function automatic logic [7:0] nibble_value(input logic [7:0] c);
		if (is_digit(c)) begin
			return c - CH_0;
		end
		if ((c >= CH_A_LO) && (c <= CH_Z_LO)) begin
			return c - CH_A_LO + NIB_TEN;
		end
		return c - CH_A_UP + NIB_TEN;
	endfunction

endpackage

// ===== hw/rtl/sks_seed_if.sv =====
`timescale 1ns / 1ps

interface sks_seed_if;
	logic              valid;
	logic              ready;
	sks_pkg::seed_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sks_key_if.sv =====
`timescale 1ns / 1ps

interface sks_key_if;
	logic             valid;
	logic             ready;
	sks_pkg::key_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/seed_to_card_key_scrambler_top.sv =====
`timescale 1ns / 1ps
// Seed characters load one per cycle while the block is in its load state.
// After the final character, a restoring division yields digit sum mod length;
// then per key byte: two store reads, each followed by a capture, then an output
// hold that waits for key.ready.
// Async reset clears count, digit sum, overflow flag and sequencer; the store is not cleared.
module seed_to_card_key_scrambler_top (
	input  logic       clk,
	input  logic       arst_n,
	sks_seed_if.sink   seed,
	sks_key_if.source  key
);
	import sks_pkg::*;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CAP  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             ovf_q;
	logic [CNT_W-1:0] rem_q;
	logic [BIT_W-1:0] bit_q;
	logic [J_W-1:0]   j_q;
	logic [7:0]       hi_q;
	logic [7:0]       rdata_q;
	logic             in_range_q;
	logic             out_valid_q;
	logic [7:0]       key_byte_q;
	logic             key_last_q;

	logic [7:0] mem [MAX_SEED_LEN];

	logic             accept;
	logic             room;
	logic [CNT_W:0]   div_t;
	logic [CNT_W:0]   div_d;
	logic [CNT_W-1:0] j_ext;
	logic [CNT_W-1:0] mirr_idx;
	logic [CNT_W-1:0] half_len;
	logic             swap;
	logic [CNT_W-1:0] m_idx;
	logic [CNT_W:0]   src;
	logic [CNT_W:0]   src_w;
	logic [7:0]       cap_char;
	logic [7:0]       cap_nib;

	assign accept = seed.valid && seed.ready;
	assign room = count_q < CNT_W'(MAX_SEED_LEN);
	assign seed.ready = (state_q == S_LOAD);

	assign key.valid = out_valid_q;
	assign key.data.key_byte = key_byte_q;
	assign key.data.key_last = key_last_q;
	assign key.data.seed_overflow = ovf_q;

	// restoring division step, one dividend bit per cycle
	assign div_t = {rem_q, sum_q[bit_q]};
	assign div_d = div_t - {1'b0, count_q};

	// position after the even-index swap, then rotation
	assign j_ext = CNT_W'(j_q);
	assign mirr_idx = count_q - CNT_W'(1) - j_ext;
	assign half_len = count_q >> 1;
	assign swap = (!j_q[0] && (j_ext < half_len)) ||
		(!mirr_idx[0] && (mirr_idx < half_len));
	assign m_idx = swap ? mirr_idx : j_ext;
	assign src = {1'b0, m_idx} + {1'b0, rem_q};
	assign src_w = (src >= {1'b0, count_q}) ? (src - {1'b0, count_q}) : src;

	assign cap_char = in_range_q ? mirror(rdata_q) : 8'h00;
	assign cap_nib = nibble_value(cap_char);

	always_ff @(posedge clk) begin
		if (accept && room) begin
			mem[count_q[ADDR_W-1:0]] <= seed.data.seed_char;
		end
		if (state_q == S_RD) begin
			rdata_q <= mem[src_w[ADDR_W-1:0]];
			in_range_q <= j_ext < count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q <= '0;
			bit_q <= '0;
			j_q <= '0;
			hi_q <= '0;
			key_byte_q <= '0;
			key_last_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
							if (is_digit(seed.data.seed_char)) begin
								sum_q <= sum_q + SUM_W'(seed.data.seed_char - CH_0);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (seed.data.seed_last) begin
							rem_q <= '0;
							bit_q <= BIT_W'(SUM_W - 1);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= div_d[CNT_W] ? div_t[CNT_W-1:0] : div_d[CNT_W-1:0];
					if (bit_q == '0) begin
						j_q <= '0;
						state_q <= S_RD;
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					if (!j_q[0]) begin
						hi_q <= cap_nib;
						j_q <= j_q + J_W'(1);
						state_q <= S_RD;
					end else begin
						key_byte_q <= {hi_q[3:0], 4'b0000} | cap_nib;
						key_last_q <= (j_q == J_W'(KEY_CHARS - 1));
						out_valid_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (key.ready) begin
						out_valid_q <= 1'b0;
						if (j_q == J_W'(KEY_CHARS - 1)) begin
							count_q <= '0;
							sum_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							j_q <= j_q + J_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== tb/seed_to_card_key_scrambler_top_test.sv =====
`timescale 1ns / 1ps

module seed_to_card_key_scrambler_top_test;
	import sks_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int ITEM_TARGET = 370;
	localparam int QUIET_FROM = 310;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;

	class KeyScoreboard;
		logic [7:0] seed_buf [MAX_SEED_LEN];
		int unsigned char_count;
		int unsigned digit_total;
		bit dropped;
		key_req_t key_queue [$];
		int errors;

		function new();
			char_count = 0;
			digit_total = 0;
			dropped = 0;
			errors = 0;
		endfunction

		function logic [7:0] nibble_of(logic [7:0] c);
			if ((c >= CH_0) && (c <= CH_9)) begin
				return c - CH_0;
			end
			if ((c >= CH_A_LO) && (c <= CH_Z_LO)) begin
				return c - CH_A_LO + NIB_TEN;
			end
			return c - CH_A_UP + NIB_TEN;
		endfunction

		function void note_char(seed_req_t r);
			logic [7:0] work [MAX_SEED_LEN];
			logic [7:0] src_c;
			logic [7:0] t;
			logic [7:0] hi;
			logic [7:0] lo;
			int unsigned len;
			int unsigned rot;
			int unsigned i;
			key_req_t k;
			if (char_count < MAX_SEED_LEN) begin
				seed_buf[char_count] = r.seed_char;
				char_count++;
				if ((r.seed_char >= CH_0) && (r.seed_char <= CH_9)) begin
					digit_total += 32'(r.seed_char - CH_0);
				end
			end else begin
				dropped = 1;
			end
			if (!r.seed_last) begin
				return;
			end
			len = char_count;
			rot = digit_total % len;
			for (i = 0; i < len; i++) begin
				src_c = seed_buf[(i + rot) % len];
				work[i] = ((src_c >= CH_0) && (src_c <= CH_9)) ? CH_9 - src_c + CH_0
					: MIRROR_K - src_c;
			end
			for (i = 0; i < len / 2; i += 2) begin
				t = work[i];
				work[i] = work[len - 1 - i];
				work[len - 1 - i] = t;
			end
			for (i = 0; i < KEY_BYTES; i++) begin
				hi = nibble_of((2 * i < len) ? work[2 * i] : 8'h00);
				lo = nibble_of((2 * i + 1 < len) ? work[2 * i + 1] : 8'h00);
				k.key_byte = {hi[3:0], 4'h0} | lo;
				k.key_last = (i == KEY_BYTES - 1);
				k.seed_overflow = dropped;
				key_queue.push_back(k);
			end
			char_count = 0;
			digit_total = 0;
			dropped = 0;
		endfunction

		function void check_key(key_req_t got);
			key_req_t want;
			if (key_queue.size() == 0) begin
				$error("unexpected key request: key_byte %02h key_last %0b seed_overflow %0b",
					got.key_byte, got.key_last, got.seed_overflow);
				errors++;
				return;
			end
			want = key_queue.pop_front();
			if (got.key_byte !== want.key_byte) begin
				$error("key_byte expected %02h actual %02h", want.key_byte, got.key_byte);
				errors++;
			end
			if (got.key_last !== want.key_last) begin
				$error("key_last expected %0b actual %0b", want.key_last, got.key_last);
				errors++;
			end
			if (got.seed_overflow !== want.seed_overflow) begin
				$error("seed_overflow expected %0b actual %0b", want.seed_overflow,
					got.seed_overflow);
				errors++;
			end
		endfunction

		function int pending();
			return key_queue.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sks_seed_if seed_ch ();
	sks_key_if key_ch ();

	KeyScoreboard sb;
	bit quiet;
	bit long_hold;
	int items_sent;
	logic [7:0] seed_text [$];

	seed_to_card_key_scrambler_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.seed   (seed_ch),
		.key    (key_ch)
	);

	initial clk = 1'b0;
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (seed_ch.valid && seed_ch.ready) begin
				sb.note_char(seed_ch.data);
			end
			if (key_ch.valid && key_ch.ready) begin
				sb.check_key(key_ch.data);
			end
		end
	end

	// key side: random stalls, plus one long hold counted here
	initial begin
		key_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				key_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold = 0;
			end else if (!quiet && ($urandom_range(0, 3) == 0)) begin
				key_ch.ready = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				key_ch.ready = 1'b1;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((seed_ch.valid && seed_ch.ready) || (key_ch.valid && key_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("seed_to_card_key_scrambler_top: mismatch");
		$finish;
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		@(negedge clk);
		seed_ch.valid = 1'b1;
		seed_ch.data = {c, last};
		@(posedge clk);
		while (!seed_ch.ready) @(posedge clk);
		items_sent++;
		if (!quiet && ($urandom_range(0, 4) == 0)) begin
			@(negedge clk);
			seed_ch.valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	task automatic push_seed();
		int i;
		for (i = 0; i < seed_text.size(); i++) begin
			send_char(seed_text[i], i == seed_text.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		int i;
		seed_text.delete();
		for (i = 0; i < s.len(); i++) begin
			seed_text.push_back(s[i]);
		end
		push_seed();
	endtask

	task automatic send_random_seed(input int len);
		logic [7:0] c;
		seed_text.delete();
		repeat (len) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c = CH_0 + 8'($urandom_range(0, 9));
				4, 5: c = CH_A_LO + 8'($urandom_range(0, 25));
				6: c = CH_A_UP + 8'($urandom_range(0, 25));
				default: c = 8'($urandom_range(0, 255));
			endcase
			seed_text.push_back(c);
		end
		push_seed();
	endtask

	initial begin
		int seed_no;
		int len;
		sb = new();
		arst_n = 1'b0;
		seed_ch.valid = 1'b0;
		seed_ch.data = '0;
		quiet = 0;
		long_hold = 0;
		items_sent = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		send_text("0");
		seed_text.delete();
		seed_text.push_back(8'h00);
		push_seed();
		seed_text.delete();
		seed_text.push_back(8'hff);
		push_seed();
		send_text("9999");
		send_text("aZ09");
		send_text("3a7Fz0Kq9m2B");
		send_text("z{");

		// exactly full store, then one past it
		send_random_seed(MAX_SEED_LEN);
		send_random_seed(MAX_SEED_LEN + 1);

		seed_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_FROM) begin
				quiet = 1;
			end
			if (seed_no == 2) begin
				long_hold = 1;
			end
			if (seed_no == 8) begin
				@(negedge clk);
				seed_ch.valid = 1'b0;
				while (sb.pending() != 0) @(negedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 16);
				7, 8: len = $urandom_range(17, MAX_SEED_LEN);
				default: len = $urandom_range(MAX_SEED_LEN + 1, MAX_SEED_LEN + 13);
			endcase
			send_random_seed(len);
			seed_no++;
		end

		@(negedge clk);
		seed_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if ((sb.errors == 0) && (sb.pending() == 0)) begin
			$display("seed_to_card_key_scrambler_top: match");
		end else begin
			$display("seed_to_card_key_scrambler_top: mismatch");
		end
		$finish;
	end

endmodule
